@@ design/shape_pair_overlap_test_assert.svh @@
// Assertion macros for the shape pair overlap test.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef SHAPE_PAIR_OVERLAP_TEST_ASSERT_SVH
`define SHAPE_PAIR_OVERLAP_TEST_ASSERT_SVH

// same-cycle implication, masked during reset
`define SPOT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, masked during reset
`define SPOT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/spot_pkg.sv @@
// Shared types and constants for the shape pair overlap test.
// No dependencies.
`default_nettype none

package spot_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	// shape kind as carried on the input
	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_BOX     = 2'd1,
		KIND_CIRCLE  = 2'd2,
		KIND_ELLIPSE = 2'd3
	} kind_t;

	// which test an item takes through the pipe
	typedef enum logic [1:0] {
		MODE_MISS  = 2'd0,
		MODE_BOX   = 2'd1,
		MODE_ROUND = 2'd2,
		MODE_NORM  = 2'd3
	} mode_t;

	// per-item control travelling with the data
	typedef struct packed {
		mode_t mode;
		logic  flag;
	} ctl_t;

endpackage

`default_nettype wire

@@ design/spot_geom.sv @@
// Geometry front end: kind dispatch, doubled centres, extents (stage 1),
// then clamped centre gaps (stage 2). Depends on spot_pkg.
`default_nettype none

module spot_geom #(
	parameter int COORD_WIDTH = spot_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    type_a,
	input  logic signed [COORD_WIDTH-1:0] a_left,
	input  logic signed [COORD_WIDTH-1:0] a_top,
	input  logic [COORD_WIDTH-2:0]        a_width,
	input  logic [COORD_WIDTH-2:0]        a_height,
	input  logic [1:0]                    type_b,
	input  logic signed [COORD_WIDTH-1:0] b_left,
	input  logic signed [COORD_WIDTH-1:0] b_top,
	input  logic [COORD_WIDTH-2:0]        b_width,
	input  logic [COORD_WIDTH-2:0]        b_height,
	output logic                          out_valid,
	input  logic                          out_ready,
	output spot_pkg::ctl_t                ctl,
	output logic [COORD_WIDTH+1:0]        ax,
	output logic [COORD_WIDTH+1:0]        ay,
	output logic [COORD_WIDTH-1:0]        sx,
	output logic [COORD_WIDTH-1:0]        sy
);

	localparam int CW = COORD_WIDTH + 2;
	localparam int SZ = COORD_WIDTH - 1;
	localparam int EW = COORD_WIDTH;

	// distance from p to the interval [lo, hi]
	function automatic logic [CW-1:0] gap(input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] lo, input logic signed [CW-1:0] hi);
		logic signed [CW:0] t;
		if (p < lo) begin
			t = (CW+1)'(lo) - (CW+1)'(p);
		end else if (p > hi) begin
			t = (CW+1)'(p) - (CW+1)'(hi);
		end else begin
			t = '0;
		end
		return t[CW-1:0];
	endfunction

	// ---- stage 1 -------------------------------------------------------
	logic signed [CW-1:0] axl, ayt, aws, ahs, bxl, byt, bws, bhs;
	logic signed [CW-1:0] a_cx, a_cy, b_cx, b_cy;
	logic [SZ-1:0]        a_min, b_min;
	logic                 bb_hit;
	spot_pkg::kind_t      ka, kb;
	spot_pkg::mode_t      mode;
	logic                 a_mov;

	// moving shape (m) and fixed shape (f)
	logic signed [CW-1:0] m_cx, m_cy, f_cx, f_cy;
	logic signed [CW-1:0] f_lox, f_hix, f_loy, f_hiy;
	logic [SZ-1:0]        m_w, m_h, m_min, f_w, f_h, f_min;
	logic                 m_circ, f_circ, f_box;

	logic signed [CW-1:0] lox_c, hix_c, loy_c, hiy_c;
	logic [EW-1:0]        sx_c, sy_c;

	assign axl = CW'(a_left);
	assign ayt = CW'(a_top);
	assign bxl = CW'(b_left);
	assign byt = CW'(b_top);
	assign aws = signed'(CW'(a_width));
	assign ahs = signed'(CW'(a_height));
	assign bws = signed'(CW'(b_width));
	assign bhs = signed'(CW'(b_height));

	assign a_cx = (axl <<< 1) + aws;
	assign a_cy = (ayt <<< 1) + ahs;
	assign b_cx = (bxl <<< 1) + bws;
	assign b_cy = (byt <<< 1) + bhs;

	assign a_min = (a_width < a_height) ? a_width : a_height;
	assign b_min = (b_width < b_height) ? b_width : b_height;

	// strict overlap: shared edges do not count
	assign bb_hit = (axl < bxl + bws) && (axl + aws > bxl) &&
	                (ayt < byt + bhs) && (ayt + ahs > byt);

	assign ka = spot_pkg::kind_t'(type_a);
	assign kb = spot_pkg::kind_t'(type_b);

	always_comb begin
		if (ka == spot_pkg::KIND_NONE || kb == spot_pkg::KIND_NONE) begin
			mode = spot_pkg::MODE_MISS;
		end else if (ka == spot_pkg::KIND_BOX && kb == spot_pkg::KIND_BOX) begin
			mode = spot_pkg::MODE_BOX;
		end else if (ka == spot_pkg::KIND_ELLIPSE || kb == spot_pkg::KIND_ELLIPSE) begin
			mode = spot_pkg::MODE_NORM;
		end else begin
			mode = spot_pkg::MODE_ROUND;
		end
	end

	// A moves when it is the circle against a box, or the non-ellipse
	// against an ellipse; otherwise B moves
	assign a_mov = (kb == spot_pkg::KIND_BOX && ka == spot_pkg::KIND_CIRCLE) ||
	               (kb == spot_pkg::KIND_ELLIPSE && ka != spot_pkg::KIND_ELLIPSE);

	always_comb begin
		if (a_mov) begin
			m_cx = a_cx;  m_cy = a_cy;  m_w = a_width;  m_h = a_height;  m_min = a_min;
			m_circ = (ka == spot_pkg::KIND_CIRCLE);
			f_cx = b_cx;  f_cy = b_cy;  f_w = b_width;  f_h = b_height;  f_min = b_min;
			f_circ = (kb == spot_pkg::KIND_CIRCLE);
			f_box  = (kb == spot_pkg::KIND_BOX);
			f_lox = bxl <<< 1;  f_hix = (bxl + bws) <<< 1;
			f_loy = byt <<< 1;  f_hiy = (byt + bhs) <<< 1;
		end else begin
			m_cx = b_cx;  m_cy = b_cy;  m_w = b_width;  m_h = b_height;  m_min = b_min;
			m_circ = (kb == spot_pkg::KIND_CIRCLE);
			f_cx = a_cx;  f_cy = a_cy;  f_w = a_width;  f_h = a_height;  f_min = a_min;
			f_circ = (ka == spot_pkg::KIND_CIRCLE);
			f_box  = (ka == spot_pkg::KIND_BOX);
			f_lox = axl <<< 1;  f_hix = (axl + aws) <<< 1;
			f_loy = ayt <<< 1;  f_hiy = (ayt + ahs) <<< 1;
		end
	end

	always_comb begin
		// centre-to-centre by default: the interval collapses to f's centre
		lox_c = f_cx;
		hix_c = f_cx;
		loy_c = f_cy;
		hiy_c = f_cy;
		sx_c  = '0;
		sy_c  = '0;
		case (mode)
			spot_pkg::MODE_ROUND: begin
				if (f_box) begin
					lox_c = f_lox;
					hix_c = f_hix;
					loy_c = f_loy;
					hiy_c = f_hiy;
				end
				// radius sum, doubled units
				sx_c = EW'(m_min) + (f_circ ? EW'(f_min) : EW'(0));
			end
			spot_pkg::MODE_NORM: begin
				sx_c = EW'(f_w) + (m_circ ? EW'(m_min) : EW'(m_w));
				sy_c = EW'(f_h) + (m_circ ? EW'(m_min) : EW'(m_h));
			end
			default: begin
			end
		endcase
	end

	// ---- stage registers -----------------------------------------------
	logic                 v_s1, v_s2, en_s1, en_s2;
	spot_pkg::ctl_t       ctl_s1, ctl_s2;
	logic signed [CW-1:0] ptx_s1, pty_s1, lox_s1, hix_s1, loy_s1, hiy_s1;
	logic [EW-1:0]        sx_s1, sy_s1, sx_s2, sy_s2;
	logic [CW-1:0]        ax_s2, ay_s2;
	spot_pkg::mode_t      mode2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctl_s1 <= '{mode: mode, flag: bb_hit};
			ptx_s1 <= m_cx;
			pty_s1 <= m_cy;
			lox_s1 <= lox_c;
			hix_s1 <= hix_c;
			loy_s1 <= loy_c;
			hiy_s1 <= hiy_c;
			sx_s1  <= sx_c;
			sy_s1  <= sy_c;
		end
	end

	// ---- stage 2: gaps, degenerate ellipse axis folds to a miss --------
	always_comb begin
		mode2 = ctl_s1.mode;
		if (ctl_s1.mode == spot_pkg::MODE_NORM && (sx_s1 == '0 || sy_s1 == '0)) begin
			mode2 = spot_pkg::MODE_MISS;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctl_s2 <= '{mode: mode2, flag: ctl_s1.flag};
			ax_s2  <= gap(ptx_s1, lox_s1, hix_s1);
			ay_s2  <= gap(pty_s1, loy_s1, hiy_s1);
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
		end
	end

	assign out_valid = v_s2;
	assign ctl       = ctl_s2;
	assign ax        = ax_s2;
	assign ay        = ay_s2;
	assign sx        = sx_s2;
	assign sy        = sy_s2;

endmodule

`default_nettype wire

@@ design/spot_mul.sv @@
// Product stage (stage 3): three shared multipliers, operands chosen by mode.
// Depends on spot_pkg.
`default_nettype none

module spot_mul #(
	parameter int COORD_WIDTH = spot_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  spot_pkg::ctl_t                        ctl,
	input  logic [COORD_WIDTH+1:0]                ax,
	input  logic [COORD_WIDTH+1:0]                ay,
	input  logic [COORD_WIDTH-1:0]                sx,
	input  logic [COORD_WIDTH-1:0]                sy,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output spot_pkg::ctl_t                        prod_ctl,
	output logic [2:0][2*(COORD_WIDTH+2)-1:0]     prod
);

	localparam int DW = COORD_WIDTH + 2;
	localparam int EW = COORD_WIDTH;
	localparam int PW = 2 * DW;

	// round: ax^2, ay^2, r^2; ellipse: ax*sy, ay*sx, sx*sy
	logic          norm;
	logic [DW-1:0] op0, op1;
	logic [EW-1:0] op2;

	assign norm = (ctl.mode == spot_pkg::MODE_NORM);
	assign op0  = norm ? DW'(sy) : ax;
	assign op1  = norm ? DW'(sx) : ay;
	assign op2  = norm ? sy : sx;

	logic                v_s3, en_s3;
	spot_pkg::ctl_t      ctl_s3;
	logic [2:0][PW-1:0]  prod_s3;

	assign en_s3    = !v_s3 || out_ready;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ctl_s3     <= ctl;
			prod_s3[0] <= PW'(ax) * PW'(op0);
			prod_s3[1] <= PW'(ay) * PW'(op1);
			prod_s3[2] <= PW'(sx) * PW'(op2);
		end
	end

	assign out_valid = v_s3;
	assign prod_ctl  = ctl_s3;
	assign prod      = prod_s3;

endmodule

`default_nettype wire

@@ design/spot_wsq.sv @@
// Wide squaring and final compare (stages 4 to 6): split-half squares,
// recombination, sum against bound, result register. Depends on spot_pkg.
`default_nettype none

module spot_wsq #(
	parameter int COORD_WIDTH = spot_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  spot_pkg::ctl_t                    ctl,
	input  logic [2:0][2*(COORD_WIDTH+2)-1:0] prod,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit
);

	localparam int PW = 2 * (COORD_WIDTH + 2);
	localparam int LW = PW / 2;
	localparam int HW = PW - LW;
	localparam int SW = 2 * PW;

	logic v_s4, v_s5, v_s6, en_s4, en_s5, en_s6;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// ---- stage 4: partial products; round test settles here ------------
	spot_pkg::ctl_t        ctl_s4, ctl_s5, ctl4;
	logic [2:0][2*HW-1:0]  hh_s4;
	logic [2:0][PW-1:0]    hl_s4;
	logic [2:0][2*LW-1:0]  ll_s4;
	logic                  round_le;

	assign round_le = ({1'b0, prod[0]} + {1'b0, prod[1]}) <= {1'b0, prod[2]};

	always_comb begin
		ctl4 = ctl;
		if (ctl.mode == spot_pkg::MODE_ROUND) begin
			ctl4.flag = round_le;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ctl_s4 <= ctl4;
			for (int i = 0; i < 3; i++) begin
				hh_s4[i] <= (2*HW)'(prod[i][PW-1:LW]) * (2*HW)'(prod[i][PW-1:LW]);
				hl_s4[i] <= PW'(prod[i][PW-1:LW]) * PW'(prod[i][LW-1:0]);
				ll_s4[i] <= (2*LW)'(prod[i][LW-1:0]) * (2*LW)'(prod[i][LW-1:0]);
			end
		end
	end

	// ---- stage 5: recombine squares ------------------------------------
	logic [2:0][SW-1:0] sq_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			ctl_s5 <= ctl_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= (SW'(hh_s4[i]) << (2*LW)) + (SW'(hl_s4[i]) << (LW+1)) +
				            SW'(ll_s4[i]);
			end
		end
	end

	// ---- stage 6: normalised test and result select --------------------
	logic norm_le, hit_c, hit_s6;

	assign norm_le = ({1'b0, sq_s5[0]} + {1'b0, sq_s5[1]}) <= {1'b0, sq_s5[2]};

	always_comb begin
		case (ctl_s5.mode)
			spot_pkg::MODE_BOX:   hit_c = ctl_s5.flag;
			spot_pkg::MODE_ROUND: hit_c = ctl_s5.flag;
			spot_pkg::MODE_NORM:  hit_c = norm_le;
			default:              hit_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			hit_s6 <= hit_c;
		end
	end

	assign out_valid = v_s6;
	assign hit       = hit_s6;

endmodule

`default_nettype wire

@@ design/shape_pair_overlap_test.sv @@
// Shape pair overlap test, top level: geometry, product and squaring pipes.
// Depends on spot_pkg, spot_geom, spot_mul, spot_wsq and the assertion header.
//
// Use:
//  - Input channel (in_valid/in_ready) carries one item per pair of shapes:
//    kind, left, top, width and height for shape A and shape B.
//  - Output channel (out_valid/out_ready) returns one item per input item,
//    the single bit hit, in input order.
//  - Six register stages: kind dispatch and centres, gap to the clamped
//    point, three shared multipliers, split-half squaring, recombination,
//    final compare.
//  - Throughput is one item per clock while out_ready is high; every stage
//    has its own valid bit, and the 2W+4 bit ellipse squaring sets the depth.
//  - Each stage advances when it is empty or the next one moves, so bubbles
//    close up under a stall; in_ready drops only when all six stages hold
//    an item and out_ready is low. A held result stays unchanged.
//  - Reset (arst_n low) empties the pipe; no state survives between items.
`default_nettype none
`include "shape_pair_overlap_test_assert.svh"

module shape_pair_overlap_test #(
	parameter int COORD_WIDTH = spot_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    type_a,
	input  logic signed [COORD_WIDTH-1:0] a_left,
	input  logic signed [COORD_WIDTH-1:0] a_top,
	input  logic [COORD_WIDTH-2:0]        a_width,
	input  logic [COORD_WIDTH-2:0]        a_height,
	input  logic [1:0]                    type_b,
	input  logic signed [COORD_WIDTH-1:0] b_left,
	input  logic signed [COORD_WIDTH-1:0] b_top,
	input  logic [COORD_WIDTH-2:0]        b_width,
	input  logic [COORD_WIDTH-2:0]        b_height,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit
);

	localparam int DW = COORD_WIDTH + 2;
	localparam int EW = COORD_WIDTH;
	localparam int PW = 2 * DW;

	// geometry -> product
	logic           g_valid, g_ready;
	spot_pkg::ctl_t g_ctl;
	logic [DW-1:0]  g_ax, g_ay;
	logic [EW-1:0]  g_sx, g_sy;

	// product -> squaring
	logic               m_valid, m_ready;
	spot_pkg::ctl_t     m_ctl;
	logic [2:0][PW-1:0] m_prod;

	// stages 1-2: dispatch on the kind pair, doubled centres, gaps
	spot_geom #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.type_a   (type_a),
		.a_left   (a_left),
		.a_top    (a_top),
		.a_width  (a_width),
		.a_height (a_height),
		.type_b   (type_b),
		.b_left   (b_left),
		.b_top    (b_top),
		.b_width  (b_width),
		.b_height (b_height),
		.out_valid(g_valid),
		.out_ready(g_ready),
		.ctl      (g_ctl),
		.ax       (g_ax),
		.ay       (g_ay),
		.sx       (g_sx),
		.sy       (g_sy)
	);

	// stage 3: squared gaps or cross products of gaps and extents
	spot_mul #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (g_valid),
		.in_ready (g_ready),
		.ctl      (g_ctl),
		.ax       (g_ax),
		.ay       (g_ay),
		.sx       (g_sx),
		.sy       (g_sy),
		.out_valid(m_valid),
		.out_ready(m_ready),
		.prod_ctl (m_ctl),
		.prod     (m_prod)
	);

	// stages 4-6: wide squares for the ellipse test, final select
	spot_wsq #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_wsq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (m_valid),
		.in_ready (m_ready),
		.ctl      (m_ctl),
		.prod     (m_prod),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit      (hit)
	);

	// ---- assertions ----------------------------------------------------
	// input back-pressure only once every stage is full
	`SPOT_ASSERT_NOW(a_stall_full, !in_ready, out_valid && !out_ready && g_valid && m_valid, "input stalled with a bubble in the pipe")
	// a zero ellipse extent must have been folded to a miss
	`SPOT_ASSERT_NOW(a_norm_extent, g_valid && g_ctl.mode == spot_pkg::MODE_NORM, g_sx != '0 && g_sy != '0, "ellipse test with zero extent")
	// nonzero extents give a nonzero bound product
	`SPOT_ASSERT_NOW(a_norm_bound, m_valid && m_ctl.mode == spot_pkg::MODE_NORM, m_prod[2] != '0, "ellipse bound product is zero")
	// a stalled product item stays put
	`SPOT_ASSERT_NXT(a_mul_hold, m_valid && !m_ready, m_valid && $stable(m_prod) && $stable(m_ctl), "product stage lost or changed a stalled item")

endmodule

`default_nettype wire
